// ===== design/dfr_pkg.sv =====
// ----------------------------------------------------------------------------
// dfr_pkg: shared types and constants of the length-prefixed packet deframer
// Holds the frame layout constants, the parser phase encoding and the result
// item structure that the parser hands to the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

   // Frame layout: 8 timestamp bytes, then 2 length bytes.
   localparam int unsigned TsBytes      = 8;
   localparam int unsigned HdrBytes     = 10;
   localparam int unsigned TosOffset    = 1;
   localparam int unsigned TotlenOffset = 2;

   localparam logic [5:0] ResetControlDscp = 6'd46;

   localparam int unsigned PosWidth = 16;
   localparam logic [PosWidth-1:0] HdrLastPos = PosWidth'(HdrBytes - 1);
   localparam logic [PosWidth-1:0] TsLenLoPos = PosWidth'(TsBytes);
   localparam logic [PosWidth-1:0] TosPos     = PosWidth'(TosOffset);
   localparam logic [PosWidth-1:0] TotHiPos   = PosWidth'(TotlenOffset);
   localparam logic [PosWidth-1:0] TotLoPos   = PosWidth'(TotlenOffset + 1);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'b01,
      PH_PAYLOAD = 2'b10
   } phase_type;

   typedef struct packed {
      logic [63:0] arrival_time;
      logic [15:0] packet_size;
      logic [5:0]  dscp_value;
      logic        is_control;
      logic        short_frame;
   } result_type;

endpackage

`default_nettype wire

// ===== design/dfr_parser.sv =====
// ----------------------------------------------------------------------------
// dfr_parser: frame parser
// Walks the header and payload of each frame one byte per accepted item and
// presents the frame's result item on the byte that ends the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                byte_en,
   input  wire logic [7:0]          data_byte,
   input  wire logic                csr_write_en,
   input  wire logic [5:0]          csr_write_data,
   output      logic                res_valid,
   output      dfr_pkg::result_type res
);

   dfr_pkg::phase_type                 phase_ff, phase_in;
   logic [dfr_pkg::PosWidth-1:0]       pos_ff, pos_in;
   logic [63:0]                        ts_ff, ts_in;
   logic [15:0]                        len_ff, len_in;
   logic [7:0]                         tos_ff, tos_in;
   logic [15:0]                        tot_ff, tot_in;
   logic [5:0]                         ctrl_ff;
   logic [dfr_pkg::PosWidth:0]         pos_next_wide;
   logic [5:0]                         dscp;

   assign pos_next_wide = {1'b0, pos_ff} + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      ts_in     = ts_ff;
      len_in    = len_ff;
      tos_in    = tos_ff;
      tot_in    = tot_ff;
      res_valid = 1'b0;
      res.arrival_time = ts_ff;
      res.packet_size  = '0;
      res.short_frame  = 1'b0;
      dscp             = '0;

      case (phase_ff)
         dfr_pkg::PH_PAYLOAD: begin
            if (pos_ff == dfr_pkg::TosPos) begin
               tos_in = data_byte;
            end else if (pos_ff == dfr_pkg::TotHiPos) begin
               tot_in = {data_byte, tot_ff[7:0]};
            end else if (pos_ff == dfr_pkg::TotLoPos) begin
               tot_in = {tot_ff[15:8], data_byte};
            end
            if (pos_next_wide >= {1'b0, len_ff}) begin
               // Last payload byte: report only the fields that arrived.
               phase_in  = dfr_pkg::PH_HEADER;
               pos_in    = '0;
               res_valid = 1'b1;
               if (len_ff > 16'(dfr_pkg::TosOffset)) begin
                  dscp = tos_in[7:2];
               end
               if (len_ff > 16'(dfr_pkg::TotlenOffset + 1)) begin
                  res.packet_size = tot_in;
               end
               res.short_frame = (len_ff < 16'd4);
            end else begin
               pos_in = pos_next_wide[dfr_pkg::PosWidth-1:0];
            end
         end
         default: begin
            // Header phase; unused codes are treated the same way.
            if (pos_ff < dfr_pkg::TsLenLoPos) begin
               for (int i = 0; i < int'(dfr_pkg::TsBytes); i++) begin
                  if (pos_ff[2:0] == 3'(i)) begin
                     ts_in[8*i +: 8] = data_byte;
                  end
               end
            end else if (pos_ff == dfr_pkg::TsLenLoPos) begin
               len_in = {len_ff[15:8], data_byte};
            end else begin
               len_in = {data_byte, len_ff[7:0]};
            end
            res.arrival_time = ts_in;
            if (pos_ff >= dfr_pkg::HdrLastPos) begin
               pos_in = '0;
               tos_in = '0;
               tot_in = '0;
               if (len_in == 16'd0) begin
                  // Empty payload closes the frame on its last header byte.
                  phase_in        = dfr_pkg::PH_HEADER;
                  res_valid       = 1'b1;
                  res.short_frame = 1'b1;
               end else begin
                  phase_in = dfr_pkg::PH_PAYLOAD;
               end
            end else begin
               pos_in = pos_next_wide[dfr_pkg::PosWidth-1:0];
            end
         end
      endcase

      res.dscp_value = dscp;
      res.is_control = (dscp == ctrl_ff);
      res_valid      = res_valid & byte_en;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dfr_pkg::PH_HEADER;
         pos_ff   <= '0;
         ctrl_ff  <= dfr_pkg::ResetControlDscp;
      end else begin
         if (byte_en) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
         end
         if (csr_write_en) begin
            ctrl_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tos_ff <= '0;
         tot_ff <= '0;
         len_ff <= '0;
      end else if (byte_en) begin
         tos_ff <= tos_in;
         tot_ff <= tot_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (byte_en) begin
         ts_ff <= ts_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/dfr_out_buf.sv =====
// ----------------------------------------------------------------------------
// dfr_out_buf: result output register with skid stage
// Holds result items for the result channel so the input side keeps moving
// while a finished result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dfr_out_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dfr_pkg::result_type push_data,
   output      logic                full,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      dfr_pkg::result_type rsp_data
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   dfr_pkg::result_type main_ff, main_in;
   dfr_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop = main_valid_ff & ~rsp_stall;

   // The user must push only while the skid stage is empty; this buffer does not enforce it.
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop || !main_valid_ff) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

`default_nettype wire

// ===== design/length_prefixed_packet_deframer.sv =====
// Each result is registered in the output register, or in the skid stage while that is busy.
// Throughput: one byte per cycle unless stalled; one result per frame of ten or more bytes.
// req_stall rises only when both the output register and its skid stage hold results.
// Reset is synchronous and active high: the parser returns to the start of a header,
// the control DSCP register returns to 46 and both result slots are emptied.
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer: framed byte stream to per-packet summary
// Each frame is an 8-byte little-endian timestamp, a 2-byte little-endian
// payload length and the IP packet bytes. One result item per frame carries
// the timestamp, IP total length, DSCP, control-class flag and short flag.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_packet_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   // Byte stream input.
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   // Per-frame result output.
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [63:0] rsp_arrival_time,
   output      logic [15:0] rsp_packet_size,
   output      logic [5:0]  rsp_dscp_value,
   output      logic        rsp_is_control,
   output      logic        rsp_short_frame,
   // Control DSCP register write.
   input  wire logic        csr_write_en,
   input  wire logic [5:0]  csr_write_data
);

   logic                byte_en;
   logic                res_valid;
   logic                buf_full;
   dfr_pkg::result_type res;
   dfr_pkg::result_type rsp_data;

   // The input side stalls only when the skid stage is occupied, so a new
   // byte can always be parsed while a single result waits downstream.
   assign req_stall = buf_full;
   assign byte_en   = req_valid & ~buf_full;

   dfr_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .byte_en        (byte_en),
      .data_byte      (req_data_byte),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .res_valid      (res_valid),
      .res            (res)
   );

   // The parser's result is registered here; the skid stage absorbs a second
   // result if the consumer stalls across a whole frame.
   dfr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_arrival_time = rsp_data.arrival_time;
   assign rsp_packet_size  = rsp_data.packet_size;
   assign rsp_dscp_value   = rsp_data.dscp_value;
   assign rsp_is_control   = rsp_data.is_control;
   assign rsp_short_frame  = rsp_data.short_frame;

endmodule

`default_nettype wire

// ===== tb/deframer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deframer_checker: result prediction and comparison for the packet deframer
// Watches the byte, result and register ports and keeps its own copy of the
// frame parser. It queues one expected summary per completed frame and checks
// every accepted result against the oldest one.
// ----------------------------------------------------------------------------

module deframer_checker
   import dfr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [63:0] rsp_arrival_time,
   input  wire logic [15:0] rsp_packet_size,
   input  wire logic [5:0]  rsp_dscp_value,
   input  wire logic        rsp_is_control,
   input  wire logic        rsp_short_frame,
   input  wire logic        csr_write_en,
   input  wire logic [5:0]  csr_write_data,
   output int               mismatch_count,
   output int               pending_results
);

   phase_type   parse_phase;
   logic [15:0] byte_index;
   logic [63:0] stamp_acc;
   logic [15:0] frame_len;
   logic [7:0]  tos_acc;
   logic [15:0] total_len_acc;
   logic [5:0]  control_dscp;
   result_type  expected_summaries[$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
   end

   // Fields whose bytes never arrived are reported as zero.
   function automatic result_type summarize_frame(input logic has_tos, input logic has_total);
      result_type summary;
      summary.arrival_time = stamp_acc;
      summary.packet_size  = has_total ? total_len_acc : 16'd0;
      summary.dscp_value   = has_tos ? tos_acc[7:2] : 6'd0;
      summary.is_control   = (summary.dscp_value == control_dscp);
      summary.short_frame  = (frame_len < 16'd4);
      return summary;
   endfunction

   task automatic absorb_byte(input logic [7:0] data);
      if (parse_phase != PH_PAYLOAD) begin
         if (byte_index < TsBytes) begin
            stamp_acc[8*byte_index +: 8] = data;
         end else if (byte_index == TsLenLoPos) begin
            frame_len[7:0] = data;
         end else begin
            frame_len[15:8] = data;
         end
         if (byte_index >= HdrLastPos) begin
            byte_index    = '0;
            tos_acc       = '0;
            total_len_acc = '0;
            if (frame_len == 16'd0) begin
               parse_phase = PH_HEADER;
               expected_summaries.push_back(summarize_frame(1'b0, 1'b0));
            end else begin
               parse_phase = PH_PAYLOAD;
            end
         end else begin
            byte_index = byte_index + 16'd1;
         end
      end else begin
         if (byte_index == TosPos) begin
            tos_acc = data;
         end else if (byte_index == TotHiPos) begin
            total_len_acc[15:8] = data;
         end else if (byte_index == TotLoPos) begin
            total_len_acc[7:0] = data;
         end
         if (32'(byte_index) + 1 >= 32'(frame_len)) begin
            parse_phase = PH_HEADER;
            byte_index  = '0;
            expected_summaries.push_back(summarize_frame(frame_len > TosPos,
                                                         frame_len > TotLoPos));
         end else begin
            byte_index = byte_index + 16'd1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] expected,
                              input logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
         mismatch_count++;
      end
   endtask

   // Inputs are driven on the rising edge with nonblocking assignments, so the
   // values read here are the ones the block sampled at this edge.
   always @(posedge clock) begin : monitor
      result_type oldest;
      if (reset) begin
         parse_phase   = PH_HEADER;
         byte_index    = '0;
         stamp_acc     = '0;
         frame_len     = '0;
         tos_acc       = '0;
         total_len_acc = '0;
         control_dscp  = ResetControlDscp;
         expected_summaries.delete();
      end else begin
         if (csr_write_en) begin
            control_dscp = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            absorb_byte(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_summaries.size() == 0) begin
               $error("unexpected result item: arrival_time %0h", rsp_arrival_time);
               mismatch_count++;
            end else begin
               oldest = expected_summaries.pop_front();
               check_field("arrival_time", oldest.arrival_time, rsp_arrival_time);
               check_field("packet_size", 64'(oldest.packet_size), 64'(rsp_packet_size));
               check_field("dscp_value", 64'(oldest.dscp_value), 64'(rsp_dscp_value));
               check_field("is_control", 64'(oldest.is_control), 64'(rsp_is_control));
               check_field("short_frame", 64'(oldest.short_frame), 64'(rsp_short_frame));
            end
         end
      end
      pending_results = expected_summaries.size();
   end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the length-prefixed packet deframer
// Sends directed frames for the empty, short and control cases, then random
// frames under several DSCP register settings and idling mixes, including a
// long receiver hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------

module testbench;
   import dfr_pkg::*;

   // No acceptance on either channel for this many cycles means a hang.
   localparam int WatchdogLimit = 5000;
   // Length of the receiver hold-off that backs the block up to its input.
   localparam int PressureHold  = 300;
   // Random bytes sent in each idling phase.
   localparam int PhaseBytes    = 55;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic [7:0]  req_data_byte  = 8'd0;
   logic        rsp_stall      = 1'b0;
   logic        csr_write_en   = 1'b0;
   logic [5:0]  csr_write_data = 6'd0;

   logic        req_stall;
   logic        rsp_valid;
   logic [63:0] rsp_arrival_time;
   logic [15:0] rsp_packet_size;
   logic [5:0]  rsp_dscp_value;
   logic        rsp_is_control;
   logic        rsp_short_frame;

   int          mismatch_count;
   int          pending_results;

   // Idling knobs, in percent per cycle, shared with the receiver process.
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;
   bit          hold_request       = 1'b0;
   int          bytes_sent         = 0;
   int          quiet_cycles       = 0;
   // Mirror of the DSCP register, used to aim random frames at the control class.
   logic [5:0]  control_setting    = ResetControlDscp;

   length_prefixed_packet_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_arrival_time (rsp_arrival_time),
      .rsp_packet_size  (rsp_packet_size),
      .rsp_dscp_value   (rsp_dscp_value),
      .rsp_is_control   (rsp_is_control),
      .rsp_short_frame  (rsp_short_frame),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   deframer_checker frame_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_arrival_time (rsp_arrival_time),
      .rsp_packet_size  (rsp_packet_size),
      .rsp_dscp_value   (rsp_dscp_value),
      .rsp_is_control   (rsp_is_control),
      .rsp_short_frame  (rsp_short_frame),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .pending_results  (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random each cycle. When a hold-off is requested it
   // keeps the stall high for a fixed stretch, counted here, so the block's
   // output register and skid stage fill and the input backs up.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = PressureHold;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // Handshakes are judged at the falling edge, where every signal has settled
   // to the value the next rising edge will see. A long stretch with no item
   // moving on either channel ends the run.
   initial begin : watchdog
      while (quiet_cycles < WatchdogLimit) begin
         @(negedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("status: fail");
      $finish;
   end

   // Offers one byte and returns at the rising edge that accepts it. Valid is
   // only lowered for idle cycles, never between back-to-back bytes, and the
   // byte is held steady while the block stalls.
   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      bytes_sent++;
   endtask

   // One frame: timestamp and length little-endian, then the payload with the
   // ToS byte and the big-endian total length at their IP offsets.
   task automatic send_frame(input logic [63:0] stamp, input logic [15:0] length,
                             input logic [7:0] tos, input logic [15:0] total_len);
      for (int i = 0; i < TsBytes; i++) begin
         send_byte(stamp[8*i +: 8]);
      end
      send_byte(length[7:0]);
      send_byte(length[15:8]);
      for (int i = 0; i < length; i++) begin
         case (i)
            TosOffset:        send_byte(tos);
            TotlenOffset:     send_byte(total_len[15:8]);
            TotlenOffset + 1: send_byte(total_len[7:0]);
            default:          send_byte(8'($urandom));
         endcase
      end
   endtask

   // A quarter of the frames are short, most are a few dozen bytes and a few
   // run to a few hundred. Half carry the control DSCP in their ToS byte.
   task automatic send_random_frame();
      int          pick;
      logic [15:0] length;
      logic [7:0]  tos;
      pick = $urandom_range(99);
      if (pick < 25) begin
         length = 16'($urandom_range(3));
      end else if (pick < 90) begin
         length = 16'($urandom_range(40, 4));
      end else begin
         length = 16'($urandom_range(300, 41));
      end
      tos = $urandom_range(1) ? {control_setting, 2'($urandom)} : 8'($urandom);
      send_frame({$urandom, $urandom}, length, tos, 16'($urandom));
   endtask

   // Stops offering bytes until every predicted result has been taken.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results != 0);
      @(posedge clock);
   endtask

   // The register is only written with the block idle. Every frame has ended
   // at this point and every predicted result has been taken.
   task automatic write_control(input logic [5:0] value);
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_write_en    <= 1'b1;
      csr_write_data  <= value;
      control_setting  = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      int first_byte;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      first_byte         = bytes_sent;
      while (bytes_sent - first_byte < PhaseBytes) begin
         send_random_frame();
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed frames with the register at its reset value. An empty payload
      // reports on the last header byte; payloads of one to three bytes leave
      // the missing fields at zero and set the short flag.
      send_frame(64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'h00, 16'h0000);
      send_frame(64'h0000_0000_0000_0000, 16'd1, 8'hFF, 16'hFFFF);
      send_frame(64'h0123_4567_89AB_CDEF, 16'd2, 8'hFF, 16'hFFFF);
      send_frame(64'h8000_0000_0000_0001, 16'd3, {ResetControlDscp, 2'b11}, 16'hFFFF);
      send_frame(64'hFEDC_BA98_7654_3210, 16'd4, 8'h00, 16'hFFFF);
      send_frame(64'h5A5A_A5A5_0F0F_F0F0, 16'd5, {ResetControlDscp, 2'b00}, 16'h0000);
      send_frame(64'h1122_3344_5566_7788, 16'h0100, 8'h55, 16'hA5C3);

      // With the register at zero, a frame that reports DSCP zero because its
      // ToS byte never arrived still counts as control traffic.
      write_control(6'd0);
      send_frame({$urandom, $urandom}, 16'd0, 8'h00, 16'h0000);
      send_frame({$urandom, $urandom}, 16'd1, 8'hFF, 16'h0000);

      // Hold the receiver off while empty frames keep coming, so the block
      // fills and stalls its input; then let everything drain.
      hold_request = 1'b1;
      repeat (8) send_frame({$urandom, $urandom}, 16'd0, 8'h00, 16'h0000);
      wait_for_results();

      run_phase(0, 0);
      write_control(6'd63);
      run_phase(83, 0);
      write_control(6'($urandom));
      run_phase(0, 83);
      write_control(ResetControlDscp);
      run_phase(35, 35);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/dfr_pkg.sv
design/dfr_parser.sv
design/dfr_out_buf.sv
design/length_prefixed_packet_deframer.sv
tb/deframer_checker.sv
tb/testbench.sv
